// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker of the four-neighbour maximum filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an expression at every rising clock edge outside reset.
`define FNMF_ASSERT_COMB(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("fnmf assertion failed");

// Checks that a consequence holds in the cycle after its cause.
`define FNMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fnmf assertion failed");

`endif

// ===== hw/rtl/fnmf_pkg.sv =====
// Shared constants, types and helper functions of the four-neighbour maximum filter.
package fnmf_pkg;

   localparam int MAX_COLS  = 1024;
   localparam int MAX_ROWS  = 1024;
   localparam int DIM_W     = 11;
   localparam int ROW_W     = $clog2(MAX_ROWS);
   localparam int COL_W     = $clog2(MAX_COLS);
   localparam int PIX_W     = 32;
   localparam int CSR_IDX_W = 8;

   localparam logic [CSR_IDX_W-1:0] REG_NUM_ROWS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_NUM_COLS = CSR_IDX_W'(1);

   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(4);

   localparam logic signed [PIX_W-1:0] INT_MIN = {1'b1, {(PIX_W-1){1'b0}}};

   localparam int BANKS  = 3;
   localparam int BANK_W = 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [ROW_W-1:0]        row;
      logic [COL_W-1:0]        col;
      logic                    has_upper;
      logic                    has_left;
      logic                    has_final;
      logic signed [PIX_W-1:0] max_upper;
      logic signed [PIX_W-1:0] max_left;
      logic signed [PIX_W-1:0] max_final;
   } entry_type;

   function automatic logic signed [PIX_W-1:0] smax(logic signed [PIX_W-1:0] a,
                                                    logic signed [PIX_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic signed [PIX_W-1:0] max4(
         logic signed [PIX_W-1:0] a, logic av,
         logic signed [PIX_W-1:0] b, logic bv,
         logic signed [PIX_W-1:0] c, logic cv,
         logic signed [PIX_W-1:0] d, logic dv);
      logic signed [PIX_W-1:0] ma;
      logic signed [PIX_W-1:0] mb;
      ma = smax(av ? a : INT_MIN, bv ? b : INT_MIN);
      mb = smax(cv ? c : INT_MIN, dv ? d : INT_MIN);
      return smax(ma, mb);
   endfunction

   function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] hi);
      if (v == '0) begin
         return DIM_W'(1);
      end
      if (v > hi) begin
         return hi;
      end
      return v;
   endfunction

   function automatic logic [BANK_W-1:0] bank_next(logic [BANK_W-1:0] b);
      return (b == BANK_W'(BANKS - 1)) ? '0 : b + BANK_W'(1);
   endfunction

   function automatic logic [BANK_W-1:0] bank_prev(logic [BANK_W-1:0] b);
      return (b == '0) ? BANK_W'(BANKS - 1) : b - BANK_W'(1);
   endfunction

endpackage

// ===== hw/rtl/fnmf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module fnmf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/fnmf_front.sv =====
// Front part: frame counters, configuration, line store and neighbour maxima of each item.
module fnmf_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [fnmf_pkg::PIX_W-1:0]     req_pixel_value,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [fnmf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [fnmf_pkg::DIM_W-1:0]            csr_data,
   input  logic [fnmf_pkg::QUEUE_CNT_W-1:0]      queue_level,
   output logic                                  push,
   output fnmf_pkg::entry_type                   push_entry
);

   typedef struct packed {
      logic [fnmf_pkg::ROW_W-1:0]        row;
      logic [fnmf_pkg::COL_W-1:0]        col;
      logic signed [fnmf_pkg::PIX_W-1:0] px;
      logic [fnmf_pkg::BANK_W-1:0]       bank_up1;
      logic [fnmf_pkg::BANK_W-1:0]       bank_up2;
      logic                              top_ok;
      logic                              up2_ok;
      logic                              left_ok;
      logic                              left2_ok;
      logic                              right_ok;
      logic                              last_row;
      logic                              is_final;
   } stage_type;

   logic [fnmf_pkg::DIM_W-1:0]  rows_ff, rows_in;
   logic [fnmf_pkg::DIM_W-1:0]  cols_ff, cols_in;
   logic [fnmf_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [fnmf_pkg::COL_W-1:0]  col_ff, col_in;
   logic [fnmf_pkg::BANK_W-1:0] bank_ff, bank_in;
   logic                        s2_valid_ff;
   stage_type                   s2_ff, s2_in;

   logic signed [fnmf_pkg::PIX_W-1:0] px_prev_ff, px_prev2_ff;
   logic signed [fnmf_pkg::PIX_W-1:0] r1_prev_ff, r1_prev2_ff;
   logic signed [fnmf_pkg::PIX_W-1:0] first_cur_ff, first_prev_ff;

   logic                              accept;
   logic                              cfg_hit;
   logic [fnmf_pkg::DIM_W-1:0]        row_inc;
   logic [fnmf_pkg::DIM_W-1:0]        col_inc;
   logic                              last_row;
   logic                              last_col;
   logic [fnmf_pkg::BANK_W-1:0]       bank_up1;
   logic [fnmf_pkg::BANK_W-1:0]       bank_up2;
   logic [fnmf_pkg::QUEUE_CNT_W:0]    reserved;
   logic [fnmf_pkg::PIX_W-1:0]        bank_rd [fnmf_pkg::BANKS];
   logic signed [fnmf_pkg::PIX_W-1:0] r1_rd, r2_rd;
   logic signed [fnmf_pkg::PIX_W-1:0] r1_first, r1_mid, r1_left;

   assign csr_ready = 1'b1;
   assign reserved  = {1'b0, queue_level} + {{fnmf_pkg::QUEUE_CNT_W{1'b0}}, s2_valid_ff};
   assign req_ready = reserved < (fnmf_pkg::QUEUE_CNT_W + 1)'(fnmf_pkg::QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;

   assign row_inc  = fnmf_pkg::DIM_W'(row_ff) + fnmf_pkg::DIM_W'(1);
   assign col_inc  = fnmf_pkg::DIM_W'(col_ff) + fnmf_pkg::DIM_W'(1);
   assign last_row = (row_inc == rows_ff);
   assign last_col = (col_inc == cols_ff);
   assign bank_up1 = fnmf_pkg::bank_prev(bank_ff);
   assign bank_up2 = fnmf_pkg::bank_prev(bank_up1);

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      bank_in = bank_ff;
      cfg_hit = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            fnmf_pkg::REG_NUM_ROWS: begin
               rows_in = fnmf_pkg::clamp_dim(csr_data, fnmf_pkg::DIM_W'(fnmf_pkg::MAX_ROWS));
               cfg_hit = 1'b1;
            end
            fnmf_pkg::REG_NUM_COLS: begin
               cols_in = fnmf_pkg::clamp_dim(csr_data, fnmf_pkg::DIM_W'(fnmf_pkg::MAX_COLS));
               cfg_hit = 1'b1;
            end
            default: begin
               cfg_hit = 1'b0;
            end
         endcase
      end
      if (cfg_hit) begin
         row_in  = '0;
         col_in  = '0;
         bank_in = '0;
      end else if (accept) begin
         if (!last_col) begin
            col_in = col_ff + fnmf_pkg::COL_W'(1);
         end else begin
            col_in = '0;
            if (last_row) begin
               row_in  = '0;
               bank_in = '0;
            end else begin
               row_in  = row_ff + fnmf_pkg::ROW_W'(1);
               bank_in = fnmf_pkg::bank_next(bank_ff);
            end
         end
      end
   end

   always_comb begin
      s2_in.row      = row_ff;
      s2_in.col      = col_ff;
      s2_in.px       = req_pixel_value;
      s2_in.bank_up1 = bank_up1;
      s2_in.bank_up2 = bank_up2;
      s2_in.top_ok   = (row_ff != '0);
      s2_in.up2_ok   = (row_ff > fnmf_pkg::ROW_W'(1));
      s2_in.left_ok  = (col_ff != '0);
      s2_in.left2_ok = (col_ff > fnmf_pkg::COL_W'(1));
      s2_in.right_ok = !last_col;
      s2_in.last_row = last_row;
      s2_in.is_final = last_row && last_col;
   end

   for (genvar k = 0; k < fnmf_pkg::BANKS; k++) begin : g_bank
      logic [fnmf_pkg::COL_W-1:0] rd_addr;
      assign rd_addr = (bank_up1 == fnmf_pkg::BANK_W'(k)) ? col_ff + fnmf_pkg::COL_W'(1)
                                                          : col_ff;
      fnmf_ram #(
         .WIDTH(fnmf_pkg::PIX_W),
         .DEPTH(fnmf_pkg::MAX_COLS)
      ) u_ram (
         .clock  (clock),
         .wr_en  (accept && (bank_ff == fnmf_pkg::BANK_W'(k))),
         .wr_addr(col_ff),
         .wr_data(req_pixel_value),
         .rd_en  (accept),
         .rd_addr(rd_addr),
         .rd_data(bank_rd[k])
      );
   end

   always_comb begin
      r1_rd = fnmf_pkg::INT_MIN;
      r2_rd = fnmf_pkg::INT_MIN;
      for (int k = 0; k < fnmf_pkg::BANKS; k++) begin
         if (s2_ff.bank_up1 == fnmf_pkg::BANK_W'(k)) begin
            r1_rd = $signed(bank_rd[k]);
         end
         if (s2_ff.bank_up2 == fnmf_pkg::BANK_W'(k)) begin
            r2_rd = $signed(bank_rd[k]);
         end
      end
   end

   // The first pixel of the row above is kept aside, as the read stream skips it.
   assign r1_first = (s2_ff.col == '0) ? first_cur_ff : first_prev_ff;
   assign r1_mid   = (s2_ff.col == '0) ? r1_first : r1_prev_ff;
   assign r1_left  = (s2_ff.col == fnmf_pkg::COL_W'(1)) ? r1_first : r1_prev2_ff;

   always_comb begin
      push_entry.row       = s2_ff.row;
      push_entry.col       = s2_ff.col;
      push_entry.has_upper = s2_ff.top_ok;
      push_entry.has_left  = s2_ff.last_row && s2_ff.left_ok;
      push_entry.has_final = s2_ff.is_final;
      push_entry.max_upper = fnmf_pkg::max4(r2_rd, s2_ff.up2_ok, s2_ff.px, 1'b1,
                                            r1_left, s2_ff.left_ok, r1_rd, s2_ff.right_ok);
      push_entry.max_left  = fnmf_pkg::max4(r1_left, s2_ff.top_ok, px_prev2_ff, s2_ff.left2_ok,
                                            s2_ff.px, 1'b1, fnmf_pkg::INT_MIN, 1'b0);
      push_entry.max_final = fnmf_pkg::max4(r1_mid, s2_ff.top_ok, px_prev_ff, s2_ff.left_ok,
                                            fnmf_pkg::INT_MIN, 1'b0, fnmf_pkg::INT_MIN, 1'b0);
   end

   assign push = s2_valid_ff &&
                 (push_entry.has_upper || push_entry.has_left || push_entry.has_final);

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff     <= fnmf_pkg::DIM_RESET;
         cols_ff     <= fnmf_pkg::DIM_RESET;
         row_ff      <= '0;
         col_ff      <= '0;
         bank_ff     <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         rows_ff     <= rows_in;
         cols_ff     <= cols_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         bank_ff     <= bank_in;
         s2_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s2_ff <= s2_in;
      end
      if (s2_valid_ff) begin
         px_prev_ff  <= s2_ff.px;
         px_prev2_ff <= px_prev_ff;
         r1_prev_ff  <= r1_rd;
         r1_prev2_ff <= r1_prev_ff;
         if (s2_ff.col == '0) begin
            first_prev_ff <= first_cur_ff;
            first_cur_ff  <= s2_ff.px;
         end
      end
   end

endmodule

// ===== hw/rtl/fnmf_queue.sv =====
// Short queue of classified items between the front and back parts.
module fnmf_queue (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  fnmf_pkg::entry_type              push_entry,
   input  logic                             pop,
   output fnmf_pkg::entry_type              head_entry,
   output logic                             empty,
   output logic [fnmf_pkg::QUEUE_CNT_W-1:0] level
);

   fnmf_pkg::entry_type                  slot_ff [fnmf_pkg::QUEUE_DEPTH];
   logic [fnmf_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [fnmf_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [fnmf_pkg::QUEUE_CNT_W-1:0]     count_ff, count_in;

   function automatic logic [fnmf_pkg::QUEUE_PTR_W-1:0] ptr_next(
         logic [fnmf_pkg::QUEUE_PTR_W-1:0] p);
      return (p == fnmf_pkg::QUEUE_PTR_W'(fnmf_pkg::QUEUE_DEPTH - 1)) ?
             '0 : p + fnmf_pkg::QUEUE_PTR_W'(1);
   endfunction

   assign head_entry = slot_ff[rd_ptr_ff];
   assign empty      = (count_ff == '0);
   assign level      = count_ff;

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + fnmf_pkg::QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - fnmf_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== hw/rtl/fnmf_back.sv =====
// Back part: splits each queued item into its results and holds the result register.
module fnmf_back (
   input  logic                              clock,
   input  logic                              reset,
   input  fnmf_pkg::entry_type               head_entry,
   input  logic                              queue_empty,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [fnmf_pkg::ROW_W-1:0]        rsp_out_row,
   output logic [fnmf_pkg::COL_W-1:0]        rsp_out_col,
   output logic signed [fnmf_pkg::PIX_W-1:0] rsp_max_value,
   output logic                              rsp_last_of_run,
   output logic                              rsp_frame_done
);

   localparam int SEL_UPPER = 0;
   localparam int SEL_LEFT  = 1;
   localparam int SEL_FINAL = 2;

   fnmf_pkg::entry_type cur_ff, cur_in;
   logic [2:0]          pend_ff, pend_in;
   logic [2:0]          pend_clr;
   logic [2:0]          pend_after;
   logic                take;
   logic                load;

   assign rsp_valid       = (pend_ff != '0);
   assign pend_clr        = pend_ff & (pend_ff - 3'd1);
   assign rsp_last_of_run = (pend_clr == '0);
   assign take            = rsp_valid && rsp_ready;
   assign pend_after      = take ? pend_clr : pend_ff;
   assign load            = (pend_after == '0) && !queue_empty;
   assign pop             = load;

   always_comb begin
      rsp_out_row    = cur_ff.row;
      rsp_out_col    = cur_ff.col;
      rsp_max_value  = cur_ff.max_final;
      rsp_frame_done = 1'b0;
      if (pend_ff[SEL_UPPER]) begin
         rsp_out_row   = cur_ff.row - fnmf_pkg::ROW_W'(1);
         rsp_max_value = cur_ff.max_upper;
      end else if (pend_ff[SEL_LEFT]) begin
         rsp_out_col   = cur_ff.col - fnmf_pkg::COL_W'(1);
         rsp_max_value = cur_ff.max_left;
      end else begin
         rsp_frame_done = pend_ff[SEL_FINAL];
      end
   end

   always_comb begin
      cur_in  = cur_ff;
      pend_in = pend_after;
      if (load) begin
         cur_in             = head_entry;
         pend_in[SEL_UPPER] = head_entry.has_upper;
         pend_in[SEL_LEFT]  = head_entry.has_left;
         pend_in[SEL_FINAL] = head_entry.has_final;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

// ===== hw/rtl/four_neighbor_max_filter.sv =====
// Four-neighbour maximum filter: top level joining the front part, the queue and the back part.
// An item passes through the front stage register and the queue into the result register.
// Throughput: one item per cycle while each item causes at most one result and no result stalls;
// last-row items, which cause up to three results, hold the input back through the four-entry queue.
// Reset is synchronous: counters, queue and result register clear, the frame returns to
// 4 x 4, and the line store is left as it is.
module four_neighbor_max_filter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [fnmf_pkg::PIX_W-1:0] req_pixel_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [fnmf_pkg::ROW_W-1:0]        rsp_out_row,
   output logic [fnmf_pkg::COL_W-1:0]        rsp_out_col,
   output logic signed [fnmf_pkg::PIX_W-1:0] rsp_max_value,
   output logic                              rsp_last_of_run,
   output logic                              rsp_frame_done,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fnmf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fnmf_pkg::DIM_W-1:0]        csr_data
);

   fnmf_pkg::entry_type              push_entry;
   fnmf_pkg::entry_type              head_entry;
   logic                             push;
   logic                             pop;
   logic                             queue_empty;
   logic [fnmf_pkg::QUEUE_CNT_W-1:0] queue_level;

   fnmf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_value(req_pixel_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .queue_level    (queue_level),
      .push           (push),
      .push_entry     (push_entry)
   );

   fnmf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .head_entry(head_entry),
      .empty     (queue_empty),
      .level     (queue_level)
   );

   fnmf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_entry     (head_entry),
      .queue_empty    (queue_empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_max_value  (rsp_max_value),
      .rsp_last_of_run(rsp_last_of_run),
      .rsp_frame_done (rsp_frame_done)
   );

endmodule

// ===== hw/rtl/fnmf_checker.sv =====
// Port-level checker of the four-neighbour maximum filter and its bind to the top level.
`include "assert_macros.svh"

module fnmf_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [fnmf_pkg::ROW_W-1:0]        rsp_out_row,
   input logic [fnmf_pkg::COL_W-1:0]        rsp_out_col,
   input logic signed [fnmf_pkg::PIX_W-1:0] rsp_max_value,
   input logic                              rsp_last_of_run,
   input logic                              rsp_frame_done
);

   // A stalled result keeps its payload.
   `FNMF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_row) && $stable(rsp_out_col) && $stable(rsp_max_value) && $stable(rsp_last_of_run) && $stable(rsp_frame_done))

   // The result for the final pixel closes the run of its item.
   `FNMF_ASSERT_COMB(a_done_last, clock, reset, !(rsp_valid && rsp_frame_done) || rsp_last_of_run)

   // The remaining results of an item follow without a gap.
   `FNMF_ASSERT_NEXT(a_run_gapless, clock, reset, rsp_valid && rsp_ready && !rsp_last_of_run, rsp_valid)

   // No result is offered right after reset.
   `FNMF_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)

endmodule

bind four_neighbor_max_filter fnmf_checker u_checker (.*);

// ===== dv/four_neighbor_max_filter_tb.sv =====
// Self-checking testbench for the four-neighbour maximum filter with a scoreboard class.
module four_neighbor_max_filter_tb;

   localparam int CYCLE_LIMIT    = 300000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int RANDOM_ITEMS   = 10;
   localparam int LONG_RUN_ITEMS = 24;
   localparam logic signed [fnmf_pkg::PIX_W-1:0] INT_MAX = ~fnmf_pkg::INT_MIN;

   typedef struct {
      logic [fnmf_pkg::ROW_W-1:0]        row;
      logic [fnmf_pkg::COL_W-1:0]        col;
      logic signed [fnmf_pkg::PIX_W-1:0] max_value;
      logic                              last_of_run;
      logic                              frame_done;
   } filter_result_type;

   class dilation_scoreboard;
      logic signed [fnmf_pkg::PIX_W-1:0] lines [3*fnmf_pkg::MAX_COLS];
      logic [fnmf_pkg::DIM_W-1:0]        rows_reg;
      logic [fnmf_pkg::DIM_W-1:0]        cols_reg;
      int unsigned                       next_row;
      int unsigned                       next_col;
      filter_result_type                 pending_maxima [$];
      int unsigned                       mismatches;
      int unsigned                       checked;
      int unsigned                       frames_closed;

      function new();
         rows_reg      = fnmf_pkg::DIM_RESET;
         cols_reg      = fnmf_pkg::DIM_RESET;
         next_row      = 0;
         next_col      = 0;
         mismatches    = 0;
         checked       = 0;
         frames_closed = 0;
      endfunction

      function int unsigned effective_size(logic [fnmf_pkg::DIM_W-1:0] v, int unsigned hi);
         if (v == '0) begin
            return 1;
         end
         if (v > hi) begin
            return hi;
         end
         return v;
      endfunction

      function int unsigned frame_pixels();
         return effective_size(rows_reg, fnmf_pkg::MAX_ROWS) *
                effective_size(cols_reg, fnmf_pkg::MAX_COLS);
      endfunction

      function void write_reg(logic [fnmf_pkg::CSR_IDX_W-1:0] idx,
                              logic [fnmf_pkg::DIM_W-1:0] data);
         if (idx == fnmf_pkg::REG_NUM_ROWS) begin
            rows_reg = data;
         end else if (idx == fnmf_pkg::REG_NUM_COLS) begin
            cols_reg = data;
         end else begin
            return;
         end
         next_row = 0;
         next_col = 0;
      endfunction

      function logic signed [fnmf_pkg::PIX_W-1:0] stored(int unsigned r, int unsigned c);
         return lines[(r % 3) * fnmf_pkg::MAX_COLS + c];
      endfunction

      function logic signed [fnmf_pkg::PIX_W-1:0] cross_max(int unsigned r, int unsigned c,
                                                            int unsigned rows,
                                                            int unsigned cols);
         logic signed [fnmf_pkg::PIX_W-1:0] m;
         m = fnmf_pkg::INT_MIN;
         if (r >= 1 && stored(r - 1, c) > m) begin
            m = stored(r - 1, c);
         end
         if (r + 1 < rows && stored(r + 1, c) > m) begin
            m = stored(r + 1, c);
         end
         if (c + 1 < cols && stored(r, c + 1) > m) begin
            m = stored(r, c + 1);
         end
         if (c >= 1 && stored(r, c - 1) > m) begin
            m = stored(r, c - 1);
         end
         return m;
      endfunction

      function void push(int unsigned r, int unsigned c, logic signed [fnmf_pkg::PIX_W-1:0] v,
                         logic last, logic done);
         filter_result_type e;
         e.row         = fnmf_pkg::ROW_W'(r);
         e.col         = fnmf_pkg::COL_W'(c);
         e.max_value   = v;
         e.last_of_run = last;
         e.frame_done  = done;
         pending_maxima.push_back(e);
      endfunction

      function void note_pixel(logic signed [fnmf_pkg::PIX_W-1:0] px);
         int unsigned rows;
         int unsigned cols;
         int unsigned i;
         int unsigned j;
         bit          has_up;
         bit          has_left;
         bit          has_final;
         rows = effective_size(rows_reg, fnmf_pkg::MAX_ROWS);
         cols = effective_size(cols_reg, fnmf_pkg::MAX_COLS);
         i    = next_row;
         j    = next_col;
         if (i >= rows || j >= cols) begin
            i = 0;
            j = 0;
         end
         lines[(i % 3) * fnmf_pkg::MAX_COLS + j] = px;
         has_up    = (i >= 1);
         has_left  = (i + 1 == rows) && (j >= 1);
         has_final = (i + 1 == rows) && (j + 1 == cols);
         if (has_up) begin
            push(i - 1, j, cross_max(i - 1, j, rows, cols), !has_left && !has_final, 1'b0);
         end
         if (has_left) begin
            push(i, j - 1, cross_max(i, j - 1, rows, cols), !has_final, 1'b0);
         end
         if (has_final) begin
            push(i, j, cross_max(i, j, rows, cols), 1'b1, 1'b1);
         end
         if (j + 1 < cols) begin
            next_row = i;
            next_col = j + 1;
         end else begin
            next_row = (i + 1 < rows) ? i + 1 : 0;
            next_col = 0;
         end
      endfunction

      function void compare(string field, longint want, longint got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(logic [fnmf_pkg::ROW_W-1:0] row,
                                 logic [fnmf_pkg::COL_W-1:0] col,
                                 logic signed [fnmf_pkg::PIX_W-1:0] value,
                                 logic last, logic done);
         filter_result_type want;
         if (pending_maxima.size() == 0) begin
            $error("unexpected result for row %0d column %0d", row, col);
            mismatches++;
            return;
         end
         want = pending_maxima.pop_front();
         checked++;
         if (done) begin
            frames_closed++;
         end
         compare("out_row", want.row, row);
         compare("out_col", want.col, col);
         compare("max_value", want.max_value, value);
         compare("last_of_run", want.last_of_run, last);
         compare("frame_done", want.frame_done, done);
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic signed [fnmf_pkg::PIX_W-1:0] req_pixel_value;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [fnmf_pkg::ROW_W-1:0]        rsp_out_row;
   logic [fnmf_pkg::COL_W-1:0]        rsp_out_col;
   logic signed [fnmf_pkg::PIX_W-1:0] rsp_max_value;
   logic                              rsp_last_of_run;
   logic                              rsp_frame_done;
   logic                              csr_valid;
   logic                              csr_ready;
   logic [fnmf_pkg::CSR_IDX_W-1:0]    csr_index;
   logic [fnmf_pkg::DIM_W-1:0]        csr_data;

   int unsigned        cycle_count   = 0;
   int unsigned        send_idle_pct = 0;
   int unsigned        recv_idle_pct = 0;
   int unsigned        pixels_sent   = 0;
   dilation_scoreboard board = new();

   four_neighbor_max_filter DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_value (req_pixel_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_max_value   (rsp_max_value),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_frame_done  (rsp_frame_done),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_result(rsp_out_row, rsp_out_col, rsp_max_value,
                            rsp_last_of_run, rsp_frame_done);
      end
   end

   function automatic logic signed [fnmf_pkg::PIX_W-1:0] pick_pixel();
      case ($urandom_range(7))
         0: return fnmf_pkg::INT_MIN;
         1: return INT_MAX;
         2: return fnmf_pkg::PIX_W'($urandom_range(8)) - fnmf_pkg::PIX_W'(4);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_pixel(input logic signed [fnmf_pkg::PIX_W-1:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_pixel_value = v;
      do @(posedge clock); while (!req_ready);
      board.note_pixel(v);
      pixels_sent++;
      @(negedge clock);
   endtask

   task automatic send_random(input int unsigned n);
      repeat (n) send_pixel(pick_pixel());
   endtask

   task automatic wait_for_quiet();
      req_valid = 1'b0;
      while (board.pending_maxima.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic program_reg(input logic [fnmf_pkg::CSR_IDX_W-1:0] idx,
                              input logic [fnmf_pkg::DIM_W-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic random_layout_burst(output int unsigned n);
      int unsigned frame;
      wait_for_quiet();
      if ($urandom_range(7) == 0) begin
         program_reg(fnmf_pkg::CSR_IDX_W'($urandom_range(2, 255)),
                     fnmf_pkg::DIM_W'($urandom));
      end
      if ($urandom_range(3) != 0) begin
         program_reg(fnmf_pkg::REG_NUM_ROWS, fnmf_pkg::DIM_W'($urandom_range(5)));
      end
      if ($urandom_range(3) != 0) begin
         program_reg(fnmf_pkg::REG_NUM_COLS, fnmf_pkg::DIM_W'($urandom_range(6)));
      end
      frame = board.frame_pixels();
      if ($urandom_range(3) == 0) begin
         n = $urandom_range(1, frame);
      end else begin
         n = frame * $urandom_range(1, 2);
      end
      send_random(n);
   endtask

   initial begin
      logic signed [fnmf_pkg::PIX_W-1:0] corner_pixels [16];
      int unsigned                       idle_send [4];
      int unsigned                       idle_recv [4];
      int unsigned                       sent_here;
      int unsigned                       burst;
      corner_pixels = '{fnmf_pkg::INT_MIN, INT_MAX, '0, -1, 1, 32'sh5555_5555,
                        32'shAAAA_AAAA, 32'sh8000_0001, 32'sh7FFF_FFFE, -2, 2,
                        fnmf_pkg::INT_MIN, fnmf_pkg::INT_MIN, fnmf_pkg::INT_MIN, INT_MAX, -1};
      idle_send       = '{0, 48, 0, 38};
      idle_recv       = '{0, 0, 48, 38};
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_pixel_value = '0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      foreach (corner_pixels[k]) begin
         send_pixel(corner_pixels[k]);
      end
      wait_for_quiet();
      program_reg(fnmf_pkg::REG_NUM_ROWS, fnmf_pkg::DIM_W'(1));
      program_reg(fnmf_pkg::REG_NUM_COLS, fnmf_pkg::DIM_W'(1));
      send_pixel(INT_MAX);
      send_pixel(fnmf_pkg::INT_MIN);
      wait_for_quiet();
      program_reg(fnmf_pkg::REG_NUM_ROWS, '0);
      program_reg(fnmf_pkg::REG_NUM_COLS, '0);
      send_random(2);
      wait_for_quiet();

      // An unknown register index must leave the frame position untouched.
      program_reg(fnmf_pkg::REG_NUM_ROWS, fnmf_pkg::DIM_W'(3));
      program_reg(fnmf_pkg::REG_NUM_COLS, fnmf_pkg::DIM_W'(3));
      send_random(4);
      wait_for_quiet();
      program_reg('1, '1);
      send_random(5);
      wait_for_quiet();

      program_reg(fnmf_pkg::REG_NUM_ROWS, fnmf_pkg::DIM_W'(1));
      program_reg(fnmf_pkg::REG_NUM_COLS, fnmf_pkg::DIM_W'(fnmf_pkg::MAX_COLS));
      send_random(LONG_RUN_ITEMS);
      wait_for_quiet();
      send_idle_pct = idle_send[3];
      recv_idle_pct = idle_recv[3];
      program_reg(fnmf_pkg::REG_NUM_ROWS, '1);
      program_reg(fnmf_pkg::REG_NUM_COLS, '0);
      send_random(LONG_RUN_ITEMS);
      wait_for_quiet();
      send_idle_pct = idle_send[1];
      recv_idle_pct = idle_recv[1];
      program_reg(fnmf_pkg::REG_NUM_ROWS, fnmf_pkg::DIM_W'(fnmf_pkg::MAX_ROWS));
      program_reg(fnmf_pkg::REG_NUM_COLS, fnmf_pkg::DIM_W'(2));
      send_random(20);

      for (int m = 0; m < 4; m++) begin
         send_idle_pct = idle_send[m];
         recv_idle_pct = idle_recv[m];
         sent_here     = 0;
         while (sent_here < RANDOM_ITEMS) begin
            random_layout_burst(burst);
            sent_here += burst;
         end
      end

      wait_for_quiet();
      $display("Sent %0d pixels over corner values, full-width, full-height and random frames.",
               pixels_sent);
      $display("Checked %0d neighbourhood maxima, %0d of them closing a frame.",
               board.checked, board.frames_closed);
      if (board.mismatches == 0 && board.pending_maxima.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/fnmf_pkg.sv
hw/rtl/fnmf_ram.sv
hw/rtl/fnmf_front.sv
hw/rtl/fnmf_queue.sv
hw/rtl/fnmf_back.sv
hw/rtl/four_neighbor_max_filter.sv
hw/rtl/fnmf_checker.sv
dv/four_neighbor_max_filter_tb.sv
